@@ rtl/fac_pkg.sv @@
// ----------------------------------------------------------------------------
// fac_pkg: shared types for the FIFO admission controller
// Event codes, controller states and the event record that travels from the
// sequencer to the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

package fac_pkg;

  localparam int ACTIVE_SLOTS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF  = 16;

  typedef enum logic [2:0] {
    EV_ADMITTED  = 3'd0,
    EV_QUEUED    = 3'd1,
    EV_RELEASED  = 3'd2,
    EV_CANCELLED = 3'd3,
    EV_REJECTED  = 3'd4,
    EV_NOTFOUND  = 3'd5
  } event_kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_REQ,
    S_HSCAN,
    S_HREL,
    S_QSCAN,
    S_QCAN,
    S_SHIFT,
    S_NOTF,
    S_ARD,
    S_ACHK,
    S_FIN
  } fac_state_t;

  typedef struct packed {
    event_kind_t kind;
    logic [31:0] ticket;
    logic [31:0] slot;
    logic [4:0]  active;
    logic [4:0]  waiting;
  } event_rec_t;

endpackage

`default_nettype wire

@@ rtl/fac_emit.sv @@
// ----------------------------------------------------------------------------
// fac_emit: event output stage
// Holds one event back until the next one (or the end of the item) is known,
// so that the final event of an item can carry its last flag.
// ----------------------------------------------------------------------------
`default_nettype none

module fac_emit
  import fac_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       produce,
  input  wire logic       finish,
  input  wire event_rec_t rec,
  output logic            can_emit,
  output logic            out_valid,
  input  wire logic       out_ready,
  output event_rec_t      out_rec,
  output logic            out_last
);

  logic       pend_valid;
  event_rec_t pend;
  logic       out_valid_next;
  logic       pend_valid_next;

  assign can_emit = !out_valid || out_ready;

  always_comb begin
    out_valid_next  = out_valid && !out_ready;
    pend_valid_next = pend_valid;
    if (produce) begin
      pend_valid_next = 1'b1;
      if (pend_valid) begin
        out_valid_next = 1'b1;
      end
    end else if (finish) begin
      out_valid_next  = 1'b1;
      pend_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      out_valid  <= out_valid_next;
      pend_valid <= pend_valid_next;
      if (produce) begin
        if (pend_valid) begin
          out_rec  <= pend;
          out_last <= 1'b0;
        end
        pend <= rec;
      end else if (finish) begin
        out_rec  <= pend;
        out_last <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/fifo_admission_controller.sv @@
// ----------------------------------------------------------------------------
// fifo_admission_controller: admission control with a strict FIFO wait queue
// Tickets are admitted into an active table or wait in a circular queue.
// ----------------------------------------------------------------------------
// Usage. Items enter on the item channel (item_valid/item_ready) and events
// leave on the event channel (event_valid/event_ready); both are valid/ready
// handshakes. One item is worked at a time: item_ready is high only while
// the controller is idle. A new request gives exactly one event. A cancel or
// release walks the active table (one entry per cycle) and, if the ticket is
// not there, the queue (one entry per cycle); it compacts the queue after a
// cancel (one entry per cycle), and then admits waiters from the head, each
// read from the queue and then admitted while its stored limit allows and
// the event receiver can take the event.
// The last event of each item carries last_result. One event is held back
// internally so that flag is known before the event is shown.
// Reset restarts the counters, clears the valid bits of the active table and the
// queue length; table and queue memories need no clearing. When the event
// receiver stalls, the controller waits at its next event and keeps all
// state until the event can be handed over.
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_admission_controller
  import fac_pkg::*;
#(
  parameter int ACTIVE_SLOTS = ACTIVE_SLOTS_DEF,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_ready,
  input  wire logic        operation,
  input  wire logic        request_valid,
  input  wire logic [15:0] active_limit,
  input  wire logic [31:0] target_ticket,
  output logic             event_valid,
  input  wire logic        event_ready,
  output logic [2:0]       event_kind,
  output logic [31:0]      event_ticket,
  output logic [31:0]      event_slot,
  output logic [4:0]       active_now,
  output logic [4:0]       waiting_now,
  output logic             last_result
);

  localparam int AW = (ACTIVE_SLOTS > 1) ? $clog2(ACTIVE_SLOTS) : 1;
  localparam int CW = $clog2(ACTIVE_SLOTS + 1);
  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int LW = $clog2(QUEUE_DEPTH + 1);

  // Control state.
  fac_state_t              state, state_next;
  logic [31:0]             ticket_counter;
  logic [31:0]             slot_counter;
  logic [ACTIVE_SLOTS-1:0] held_valid;
  logic [CW-1:0]           live_count;
  logic [QW-1:0]           queue_head;
  logic [LW-1:0]           queue_length;

  // Latched item.
  logic        req_valid_r;
  logic [15:0] limit_r;
  logic [31:0] target_r;

  // Walk counters.
  logic [CW-1:0] scan_idx;
  logic          chk_pend;
  logic [AW-1:0] chk_idx;
  logic [AW-1:0] hit_idx;
  logic [LW-1:0] qscan;
  logic          qchk_pend;
  logic [LW-1:0] qchk_pos;
  logic [LW-1:0] sh_rd;
  logic          sh_pend;
  logic [QW-1:0] sh_waddr;

  // Active table memory: {ticket, slot}.
  logic [63:0]   held_mem [ACTIVE_SLOTS];
  logic          h_we, h_re;
  logic [AW-1:0] h_waddr, h_raddr;
  logic [63:0]   h_wdata, h_rdata;

  // Queue memory: {ticket, clamped limit}.
  logic [CW+31:0] q_mem [QUEUE_DEPTH];
  logic           q_we, q_re;
  logic [QW-1:0]  q_waddr, q_raddr;
  logic [CW+31:0] q_wdata, q_rdata;

  // Update strobes.
  logic tick_inc, slot_inc, act_inc, act_dec, len_inc, len_dec, head_inc;
  logic valid_set, valid_clr;

  logic          produce, finish, can_emit;
  event_rec_t    rec, out_rec;
  logic          out_last;

  logic [AW-1:0] free_idx;
  logic [CW-1:0] lim_c;
  logic          hit, qhit, adm_ok;

  // Physical queue address of a position counted from the head.
  function automatic logic [QW-1:0] qaddr(input logic [QW-1:0] head,
                                          input logic [LW-1:0] pos);
    logic [LW:0] s;
    s = (LW+1)'(head) + (LW+1)'(pos);
    if (s >= (LW+1)'(QUEUE_DEPTH)) begin
      s = s - (LW+1)'(QUEUE_DEPTH);
    end
    return s[QW-1:0];
  endfunction

  // Lowest free entry of the active table.
  always_comb begin
    free_idx = '0;
    for (int i = ACTIVE_SLOTS - 1; i >= 0; i--) begin
      if (!held_valid[i]) begin
        free_idx = AW'(i);
      end
    end
  end

  assign lim_c  = (limit_r > 16'(ACTIVE_SLOTS)) ? CW'(ACTIVE_SLOTS) : CW'(limit_r);
  assign hit    = chk_pend && held_valid[chk_idx] && (h_rdata[63:32] == target_r);
  assign qhit   = qchk_pend && (q_rdata[CW+31:CW] == target_r);
  assign adm_ok = live_count < q_rdata[CW-1:0];

  assign item_ready = (state == S_IDLE);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          state_next = operation ? S_HSCAN : S_REQ;
        end
      end
      S_REQ: begin
        if (can_emit) begin
          state_next = S_FIN;
        end
      end
      S_HSCAN: begin
        if (hit) begin
          state_next = S_HREL;
        end else if (scan_idx == CW'(ACTIVE_SLOTS) && !chk_pend) begin
          state_next = S_QSCAN;
        end
      end
      S_HREL: begin
        if (can_emit) begin
          state_next = S_ARD;
        end
      end
      S_QSCAN: begin
        if (qhit) begin
          state_next = S_QCAN;
        end else if (qscan == queue_length && !qchk_pend) begin
          state_next = S_NOTF;
        end
      end
      S_QCAN: begin
        if (can_emit) begin
          state_next = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (sh_rd > queue_length && !sh_pend) begin
          state_next = S_ARD;
        end
      end
      S_NOTF: begin
        if (can_emit) begin
          state_next = S_ARD;
        end
      end
      S_ARD: begin
        state_next = (queue_length == '0) ? S_FIN : S_ACHK;
      end
      S_ACHK: begin
        if (!adm_ok) begin
          state_next = S_FIN;
        end else if (can_emit) begin
          state_next = S_ARD;
        end
      end
      S_FIN: begin
        if (can_emit) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath control.
  always_comb begin
    produce     = 1'b0;
    finish      = 1'b0;
    rec.kind    = EV_REJECTED;
    rec.ticket  = '0;
    rec.slot    = '0;
    rec.active  = 5'(live_count);
    rec.waiting = 5'(queue_length);
    h_we = 1'b0;  h_waddr = free_idx;  h_wdata = {ticket_counter, slot_counter};
    h_re = 1'b0;  h_raddr = scan_idx[AW-1:0];
    q_we = 1'b0;  q_waddr = qaddr(queue_head, queue_length);
    q_wdata = {ticket_counter, lim_c};
    q_re = 1'b0;  q_raddr = qaddr(queue_head, qscan);
    tick_inc = 1'b0; slot_inc = 1'b0; act_inc = 1'b0; act_dec = 1'b0;
    len_inc = 1'b0;  len_dec = 1'b0;  head_inc = 1'b0;
    valid_set = 1'b0; valid_clr = 1'b0;
    case (state)
      S_REQ: begin
        if (can_emit) begin
          produce = 1'b1;
          if (!req_valid_r || limit_r == 16'd0) begin
            rec.kind = EV_REJECTED;
          end else begin
            tick_inc   = 1'b1;
            rec.ticket = ticket_counter;
            if (queue_length == '0 && live_count < lim_c) begin
              rec.kind   = EV_ADMITTED;
              rec.slot   = slot_counter;
              rec.active = 5'(live_count + CW'(1));
              h_we = 1'b1; valid_set = 1'b1; slot_inc = 1'b1; act_inc = 1'b1;
            end else if (queue_length >= LW'(QUEUE_DEPTH)) begin
              rec.kind = EV_REJECTED;
            end else begin
              rec.kind    = EV_QUEUED;
              rec.waiting = 5'(queue_length + LW'(1));
              q_we = 1'b1; len_inc = 1'b1;
            end
          end
        end
      end
      S_HSCAN: begin
        h_re = !hit && (scan_idx < CW'(ACTIVE_SLOTS));
      end
      S_HREL: begin
        if (can_emit) begin
          produce    = 1'b1;
          rec.kind   = EV_RELEASED;
          rec.ticket = target_r;
          rec.slot   = h_rdata[31:0];
          rec.active = 5'(live_count - CW'(1));
          valid_clr = 1'b1; act_dec = 1'b1;
        end
      end
      S_QSCAN: begin
        q_re = !qhit && (qscan < queue_length);
      end
      S_QCAN: begin
        if (can_emit) begin
          produce     = 1'b1;
          rec.kind    = EV_CANCELLED;
          rec.ticket  = target_r;
          rec.waiting = 5'(queue_length - LW'(1));
          len_dec = 1'b1;
        end
      end
      S_SHIFT: begin
        // Entries behind the cancelled one move one place toward the head.
        q_re    = (sh_rd <= queue_length);
        q_raddr = qaddr(queue_head, sh_rd);
        q_we    = sh_pend;
        q_waddr = sh_waddr;
        q_wdata = q_rdata;
      end
      S_NOTF: begin
        if (can_emit) begin
          produce    = 1'b1;
          rec.kind   = EV_NOTFOUND;
          rec.ticket = target_r;
        end
      end
      S_ARD: begin
        q_re    = (queue_length != '0);
        q_raddr = queue_head;
      end
      S_ACHK: begin
        if (adm_ok && can_emit) begin
          produce     = 1'b1;
          rec.kind    = EV_ADMITTED;
          rec.ticket  = q_rdata[CW+31:CW];
          rec.slot    = slot_counter;
          rec.active  = 5'(live_count + CW'(1));
          rec.waiting = 5'(queue_length - LW'(1));
          h_we    = 1'b1;
          h_wdata = {q_rdata[CW+31:CW], slot_counter};
          valid_set = 1'b1; slot_inc = 1'b1; act_inc = 1'b1;
          len_dec = 1'b1; head_inc = 1'b1;
        end
      end
      S_FIN: begin
        finish = can_emit;
      end
      default: ;
    endcase
  end

  // Memories.
  always_ff @(posedge clk) begin
    if (h_we) begin
      held_mem[h_waddr] <= h_wdata;
    end
    if (h_re) begin
      h_rdata <= held_mem[h_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[q_waddr] <= q_wdata;
    end
    if (q_re) begin
      q_rdata <= q_mem[q_raddr];
    end
  end

  // Registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      ticket_counter <= 32'd0;
      slot_counter   <= 32'd1;
      held_valid     <= '0;
      live_count     <= '0;
      queue_head     <= '0;
      queue_length   <= '0;
      chk_pend       <= 1'b0;
      qchk_pend      <= 1'b0;
      sh_pend        <= 1'b0;
      scan_idx       <= '0;
      qscan          <= '0;
    end else begin
      state <= state_next;
      if (tick_inc) ticket_counter <= ticket_counter + 32'd1;
      if (slot_inc) slot_counter <= slot_counter + 32'd1;
      if (valid_set) held_valid[free_idx] <= 1'b1;
      if (valid_clr) held_valid[hit_idx] <= 1'b0;
      if (act_inc) live_count <= live_count + CW'(1);
      if (act_dec) live_count <= live_count - CW'(1);
      if (len_inc) queue_length <= queue_length + LW'(1);
      if (len_dec) queue_length <= queue_length - LW'(1);
      if (head_inc) begin
        queue_head <= (queue_head == QW'(QUEUE_DEPTH - 1)) ? '0 : queue_head + QW'(1);
      end
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            req_valid_r <= request_valid;
            limit_r     <= active_limit;
            target_r    <= target_ticket;
            scan_idx    <= '0;
            qscan       <= '0;
            chk_pend    <= 1'b0;
            qchk_pend   <= 1'b0;
            sh_pend     <= 1'b0;
          end
        end
        S_HSCAN: begin
          chk_pend <= h_re;
          if (h_re) begin
            chk_idx  <= scan_idx[AW-1:0];
            scan_idx <= scan_idx + CW'(1);
          end
          if (hit) hit_idx <= chk_idx;
        end
        S_QSCAN: begin
          qchk_pend <= q_re;
          if (q_re) begin
            qchk_pos <= qscan;
            qscan    <= qscan + LW'(1);
          end
          if (qhit) sh_rd <= qchk_pos + LW'(1);
        end
        S_SHIFT: begin
          sh_pend <= q_re;
          if (q_re) begin
            sh_waddr <= qaddr(queue_head, sh_rd - LW'(1));
            sh_rd    <= sh_rd + LW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  fac_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .produce   (produce),
    .finish    (finish),
    .rec       (rec),
    .can_emit  (can_emit),
    .out_valid (event_valid),
    .out_ready (event_ready),
    .out_rec   (out_rec),
    .out_last  (out_last)
  );

  assign event_kind   = out_rec.kind;
  assign event_ticket = out_rec.ticket;
  assign event_slot   = out_rec.slot;
  assign active_now   = out_rec.active;
  assign waiting_now  = out_rec.waiting;
  assign last_result  = out_last;

  // The live count always matches the number of valid table entries.
  a_count: assert property (@(posedge clk) disable iff (rst)
    live_count == CW'($countones(held_valid)))
    else $error("live count out of step with valid bits");

  // The queue never holds more than its depth.
  a_qlen: assert property (@(posedge clk) disable iff (rst)
    queue_length <= LW'(QUEUE_DEPTH))
    else $error("queue length beyond depth");

  // An event is only handed on when the output stage can take it.
  a_emit: assert property (@(posedge clk) disable iff (rst)
    (produce || finish) |-> can_emit)
    else $error("event produced while output stage is full");

  // An accepted item always starts work.
  a_start: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> state != S_IDLE)
    else $error("accepted item left the controller idle");

endmodule

`default_nettype wire
